FILE: src/rre_pkg.sv
package rre_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int BALL_W       = 8;
  localparam int ROLL_W       = 16;
  localparam int LEFT_W       = 11;
  localparam int DIV_STEP_W   = $clog2(ROLL_W);
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 24;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TURN = 1'b1
  } kind_t;

endpackage

FILE: src/rre_ram.sv
module rre_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rre_moddiv.sv
module rre_moddiv #(
  parameter int DIVISOR_W = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rre_pkg::ROLL_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]       divisor,
  output logic                       done,
  output logic [DIVISOR_W-1:0]       remainder
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [rre_pkg::DIV_STEP_W-1:0] step_r, step_nxt;
  logic [rre_pkg::ROLL_W-1:0]     quot_r, quot_nxt;
  logic [DIVISOR_W-1:0]           rem_r, rem_nxt;
  logic [DIVISOR_W:0]             trial;
  logic [DIVISOR_W:0]             trial_sub;

  // restoring division, one dividend bit per cycle, only the remainder is kept
  assign trial     = {rem_r, quot_r[rre_pkg::ROLL_W-1]};
  assign trial_sub = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quot_nxt = {quot_r[rre_pkg::ROLL_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial_sub[DIVISOR_W-1:0];
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
      end
      step_nxt = step_r + 1'b1;
      if (step_r == rre_pkg::DIV_STEP_W'(rre_pkg::ROLL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: src/rotating_ring_extract_core.sv
// loads: a load is written straight to the end of the store when it lands there, otherwise
//   a gap is opened before the head through the memory port (S_UP), then the load is written (S_INS)
// turns: a turn first reduces the roll modulo count in rre_moddiv (S_DIV), then makes one memory
//   pass that closes the gap (S_RDH, S_DN, S_OUT); a turn on an empty ring goes straight to S_OUT
// throughput: one item at a time, set by the shift pass over the ring memory's one read and one write port
// reset: synchronous active low rst_n clears count, head, state and output valid
module rotating_ring_extract_core #(
  parameter int CAPACITY = rre_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rre_pkg::IN_TDATA_W-1:0]  in_tdata,   // ball_char[7:0], roll[23:8]
  input  logic                            in_tuser,   // kind[0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rre_pkg::OUT_TDATA_W-1:0] out_tdata,  // taken_ball[7:0], left_count[18:8]
  output logic                            out_tuser   // was_empty[0]
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RDH,
    S_DN,
    S_UP,
    S_INS,
    S_OUT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [IW-1:0]                  head_r, head_nxt;
  logic [CW-1:0]                  pos_r, pos_nxt;
  logic                           first_r, first_nxt;
  logic [rre_pkg::BALL_W-1:0]     ball_r, ball_nxt;
  logic [rre_pkg::BALL_W-1:0]     res_ball_r, res_ball_nxt;
  logic                           res_empty_r, res_empty_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [rre_pkg::BALL_W-1:0]     out_ball_r, out_ball_nxt;
  logic                           out_empty_r, out_empty_nxt;
  logic [rre_pkg::LEFT_W-1:0]     out_left_r, out_left_nxt;

  logic                           in_acc;
  rre_pkg::kind_t                 in_kind;
  logic [rre_pkg::BALL_W-1:0]     in_ball;
  logic [rre_pkg::ROLL_W-1:0]     in_roll;
  logic [rre_pkg::ROLL_W-1:0]     roll_mag;
  logic                           roll_neg;
  logic                           neg_r, neg_nxt;

  logic                           div_start;
  logic                           div_done;
  logic [CW-1:0]                  div_rem;

  logic                           mem_we;
  logic [IW-1:0]                  mem_waddr;
  logic [rre_pkg::BALL_W-1:0]     mem_wdata;
  logic [IW-1:0]                  mem_raddr;
  logic [rre_pkg::BALL_W-1:0]     mem_rdata;

  logic [CW:0]                    head_ext;
  logic [CW:0]                    cnt_ext;
  logic [CW:0]                    rot_sum;
  logic [CW:0]                    rot_wrap;
  logic [CW-1:0]                  cnt_dec;
  logic [CW-1:0]                  pos_dec2;
  logic [CW-1:0]                  pos_inc2;
  logic [CW+rre_pkg::LEFT_W-1:0]  cnt_wide;
  logic [CW-1:0]                  head_cw;

  assign in_acc   = in_tvalid && in_tready;
  assign in_kind  = rre_pkg::kind_t'(in_tuser);
  assign in_ball  = in_tdata[rre_pkg::BALL_W-1:0];
  assign in_roll  = in_tdata[rre_pkg::BALL_W +: rre_pkg::ROLL_W];
  assign roll_neg = in_roll[rre_pkg::ROLL_W-1];
  assign roll_mag = roll_neg ? (~in_roll + 1'b1) : in_roll;

  assign head_ext = {{(CW + 1 - IW){1'b0}}, head_r};
  assign head_cw  = head_ext[CW-1:0];
  assign cnt_ext  = {1'b0, cnt_r};
  assign cnt_dec  = cnt_r - 1'b1;
  assign pos_dec2 = pos_r - CW'(2);
  assign pos_inc2 = pos_r + CW'(2);
  assign cnt_wide = {{rre_pkg::LEFT_W{1'b0}}, cnt_r};

  // head moved by the roll remainder, kept in [0, count) with one subtract
  assign rot_sum  = neg_r ? (head_ext + cnt_ext - {1'b0, div_rem})
                          : (head_ext + {1'b0, div_rem});
  assign rot_wrap = (rot_sum >= cnt_ext) ? (rot_sum - cnt_ext) : rot_sum;

  assign in_tready = (state_r == S_IDLE);
  assign div_start = in_acc && (in_kind == rre_pkg::KIND_TURN) && (cnt_r != '0);

  rre_moddiv #(
    .DIVISOR_W (CW)
  ) u_moddiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (roll_mag),
    .divisor   (cnt_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  rre_ram #(
    .DATA_W (rre_pkg::BALL_W),
    .DEPTH  (CAPACITY)
  ) u_ring_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    pos_nxt       = pos_r;
    first_nxt     = first_r;
    ball_nxt      = ball_r;
    neg_nxt       = neg_r;
    res_ball_nxt  = res_ball_r;
    res_empty_nxt = res_empty_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ball_nxt  = out_ball_r;
    out_empty_nxt = out_empty_r;
    out_left_nxt  = out_left_r;
    mem_we        = 1'b0;
    mem_waddr     = head_r;
    mem_wdata     = ball_r;
    mem_raddr     = pos_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind == rre_pkg::KIND_LOAD) begin
            if (cnt_r < CW'(CAPACITY)) begin
              if ((head_r == '0) || (head_cw >= cnt_r)) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[IW-1:0];
                mem_wdata = in_ball;
                cnt_nxt   = cnt_r + 1'b1;
              end else begin
                // open a gap before the head, moving entries up from the top
                ball_nxt  = in_ball;
                pos_nxt   = cnt_dec;
                first_nxt = 1'b1;
                state_nxt = S_UP;
              end
            end
          end else if (cnt_r == '0) begin
            res_ball_nxt  = '0;
            res_empty_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            if (head_cw >= cnt_r) begin
              head_nxt = '0;
            end
            neg_nxt   = roll_neg;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          head_nxt  = rot_wrap[IW-1:0];
          state_nxt = S_RDH;
        end
      end
      S_RDH: begin
        mem_raddr = head_r;
        pos_nxt   = head_cw + 1'b1;
        first_nxt = 1'b1;
        state_nxt = S_DN;
      end
      S_DN: begin
        // read data belongs to pos - 1, it moves down one place
        if (first_r) begin
          res_ball_nxt  = mem_rdata;
          res_empty_nxt = 1'b0;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pos_dec2[IW-1:0];
          mem_wdata = mem_rdata;
        end
        first_nxt = 1'b0;
        if (pos_r == cnt_r) begin
          cnt_nxt   = cnt_dec;
          if (head_cw >= cnt_dec) begin
            head_nxt = '0;
          end
          state_nxt = S_OUT;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_UP: begin
        // read data belongs to pos + 1, it moves up one place
        if (!first_r) begin
          mem_we    = 1'b1;
          mem_waddr = pos_inc2[IW-1:0];
          mem_wdata = mem_rdata;
        end
        first_nxt = 1'b0;
        if (pos_r >= head_cw) begin
          pos_nxt = pos_r - 1'b1;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = head_r;
        mem_wdata = ball_r;
        head_nxt  = head_r + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ball_nxt  = res_ball_r;
          out_empty_nxt = res_empty_r;
          out_left_nxt  = cnt_wide[rre_pkg::LEFT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    ball_r      <= ball_nxt;
    neg_r       <= neg_nxt;
    res_ball_r  <= res_ball_nxt;
    res_empty_r <= res_empty_nxt;
    out_ball_r  <= out_ball_nxt;
    out_empty_r <= out_empty_nxt;
    out_left_r  <= out_left_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_empty_r;
  assign out_tdata  = {{(rre_pkg::OUT_TDATA_W - rre_pkg::BALL_W - rre_pkg::LEFT_W){1'b0}},
                       out_left_r, out_ball_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("ball count above capacity");

  a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (cnt_r != '0) |-> (head_cw < cnt_r))
    else $error("head outside the ring while idle");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> (out_ball_r == '0) && (out_left_r == '0))
    else $error("empty turn result carries data");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == rre_pkg::KIND_LOAD) && (cnt_r == CW'(CAPACITY)) |=> $stable(cnt_r))
    else $error("load into a full ring changed the count");

  a_turn_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("remainder ready outside a turn");

endmodule
